### hw/rtl/smmg_pkg.sv
// Shared types and constants for the set min/max gap tracker.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package smmg_pkg;

  localparam int VAL_W = 32;
  localparam int CAP_W = 7;
  localparam int GAP_W = 33;

  // Input op codes.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Command kinds passed from the front to the back.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_REFUSE = 2'd2;

  typedef struct packed {
    logic                    op;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic             refused;
    logic [CAP_W-1:0] held_count;
    logic [VAL_W-1:0] shortest_span;
    logic [VAL_W-1:0] longest_span;
  } out_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/smmg_front.sv
// Front end of the set min/max gap tracker: accepts input transfers, holds
// the capacity register and classifies each item. Depends on smmg_pkg.
`default_nettype none

module smmg_front #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [smmg_pkg::CAP_W-1:0]    cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  smmg_pkg::in_t                in_data,
  output logic                         cmd_valid,
  input  wire                          cmd_ready,
  output smmg_pkg::cmd_t               cmd_data
);
  import smmg_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity_limit;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic             take;

  assign cap_ext = CMP_W'(capacity_limit);
  assign cap_eff = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
  assign cnt_ext = CMP_W'(count);
  assign full    = (cnt_ext >= cap_eff);

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign take      = in_valid && cmd_ready;

  always_comb begin
    cmd_data.value = in_data.value;
    count_next     = count;
    if (in_data.op == OP_CLEAR) begin
      cmd_data.kind = CMD_CLEAR;
      count_next    = '0;
    end else if (full) begin
      cmd_data.kind = CMD_REFUSE;
    end else begin
      cmd_data.kind = CMD_ADD;
      count_next    = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_W'(64);
      count          <= '0;
    end else begin
      if (cfg_we) begin
        capacity_limit <= cfg_data;
      end
      if (take) begin
        count <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/smmg_queue.sv
// Two-entry command queue between the front and back of the tracker.
// Depends on smmg_pkg for the command type.
`default_nettype none

module smmg_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  smmg_pkg::cmd_t  push_data,
  output logic            can_push,
  input  wire             pop,
  output logic            can_pop,
  output smmg_pkg::cmd_t  pop_data
);
  import smmg_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign can_push = (fill != 2'd2);
  assign can_pop  = (fill != 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && can_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && can_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && can_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && can_push, pop && can_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/smmg_back.sv
// Back end of the tracker: value memory, sequential gap scan, running
// min/max and the output register. Depends on smmg_pkg.
`default_nettype none

module smmg_back #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             cmd_valid,
  output logic            cmd_pop,
  input  smmg_pkg::cmd_t  cmd_data,
  output logic            out_valid,
  input  wire             out_ready,
  output smmg_pkg::out_t  out_data
);
  import smmg_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]              state;
  logic signed [VAL_W-1:0] cur_value;
  logic                    cur_refused;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] smallest_seen;
  logic signed [VAL_W-1:0] largest_seen;
  logic [GAP_W-1:0]        min_gap;

  logic [VAL_W-1:0]        mem [MAX_ENTRIES];
  logic [VAL_W-1:0]        rd_data;
  logic [CNT_W-1:0]        rd_idx;
  logic                    rd_v;
  logic                    gap_v;
  logic [GAP_W-1:0]        gap;

  logic [GAP_W-1:0]        diff_a;
  logic [GAP_W-1:0]        diff_b;
  logic [GAP_W-1:0]        span_full;
  logic                    out_free;
  logic                    two_held;

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign out_free = !out_valid || out_ready;
  assign two_held = (count >= CNT_W'(2));

  // Both orders of the difference in parallel; the sign picks the magnitude.
  assign diff_a    = {cur_value[VAL_W-1], cur_value} - {rd_data[VAL_W-1], rd_data};
  assign diff_b    = {rd_data[VAL_W-1], rd_data} - {cur_value[VAL_W-1], cur_value};
  assign span_full = {largest_seen[VAL_W-1], largest_seen}
                   - {smallest_seen[VAL_W-1], smallest_seen};

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx[IDX_W-1:0]];
    if (state == S_FIN) begin
      mem[count[IDX_W-1:0]] <= cur_value;
    end
  end

  always_ff @(posedge clk) begin
    gap <= diff_a[GAP_W-1] ? diff_b : diff_a;
    if (state == S_IDLE && cmd_valid) begin
      cur_value <= cmd_data.value;
    end
    if (state == S_RES && out_free) begin
      out_data.refused       <= cur_refused;
      out_data.held_count    <= CAP_W'(count);
      out_data.shortest_span <= two_held ? min_gap[VAL_W-1:0] : '0;
      out_data.longest_span  <= two_held ? span_full[VAL_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cur_refused   <= 1'b0;
      count         <= '0;
      smallest_seen <= '0;
      largest_seen  <= '0;
      min_gap       <= '1;
      rd_idx        <= '0;
      rd_v          <= 1'b0;
      gap_v         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // In S_RES a free output register is reloaded below instead.
      if (out_valid && out_ready && (state != S_RES)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_idx <= '0;
          rd_v   <= 1'b0;
          gap_v  <= 1'b0;
          if (cmd_valid) begin
            cur_refused <= (cmd_data.kind == CMD_REFUSE);
            case (cmd_data.kind)
              CMD_CLEAR: begin
                count         <= '0;
                smallest_seen <= '0;
                largest_seen  <= '0;
                min_gap       <= '1;
                state         <= S_RES;
              end
              CMD_REFUSE: begin
                state <= S_RES;
              end
              default: begin
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          // One stored value read per cycle, then difference, then compare.
          if (rd_idx != count) begin
            rd_idx <= rd_idx + CNT_W'(1);
            rd_v   <= 1'b1;
          end else begin
            rd_v <= 1'b0;
          end
          gap_v <= rd_v;
          if (gap_v && (gap < min_gap)) begin
            min_gap <= gap;
          end
          if (rd_idx == count && !rd_v && !gap_v) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (count == '0) begin
            smallest_seen <= cur_value;
            largest_seen  <= cur_value;
          end else begin
            if (cur_value < smallest_seen) begin
              smallest_seen <= cur_value;
            end
            if (cur_value > largest_seen) begin
              largest_seen <= cur_value;
            end
          end
          count <= count + CNT_W'(1);
          state <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/set_min_max_gap_tracker.sv
// Set min/max gap tracker, top level; depends on smmg_pkg, smmg_front, smmg_queue, smmg_back.
// A clear or a refused add passes from the input transfer through a queue slot and the back
// end's S_IDLE and S_RES states to the output register; an add also passes S_SCAN and S_FIN,
// where the scan reads one stored value per cycle, so it lasts longer the more values are held.
// The back end takes one item at a time, popping it in S_IDLE; output stalls hold it in S_RES.
// Reset (rst, synchronous) empties the set and queue, capacity 64; memory is not cleared.
`default_nettype none

module set_min_max_gap_tracker #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire [smmg_pkg::CAP_W-1:0] cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  smmg_pkg::in_t             in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output smmg_pkg::out_t            out_data
);
  import smmg_pkg::*;

  // The front keeps its own count of held values so it can decide on
  // refusal at the moment of the input transfer, without waiting for the
  // back end. Both counts follow the same command stream, so they agree.
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_data;

  // The back end pops one command at a time from the queue.
  logic qb_valid;
  logic qb_pop;
  cmd_t qb_data;

  smmg_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  // A short queue lets the front keep taking transfers while the back end
  // scans or while a finished result waits in the output register.
  smmg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_valid),
    .push_data (fq_data),
    .can_push  (fq_ready),
    .pop       (qb_pop),
    .can_pop   (qb_valid),
    .pop_data  (qb_data)
  );

  // The back end holds the values, scans them for the smallest gap and
  // drives the registered output.
  smmg_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_pop   (qb_pop),
    .cmd_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### dv/set_min_max_gap_tracker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for set_min_max_gap_tracker: random and directed adds and clears
// against a span predictor kept in a scoreboard class. Depends on smmg_pkg and the RTL.

module set_min_max_gap_tracker_tb;
  import smmg_pkg::*;

  localparam int STORE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 1800;
  // The slowest add scans 63 stored values; the long receiver hold-off below and a sender gap
  // also pass without a transfer. The limit leaves several times their sum.
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 80;

  // Scoreboard: keeps its own copy of the set and the capacity register, works out the
  // result of every accepted transfer and compares the block's results in order.
  class span_scoreboard;
    int              held_vals[STORE_DEPTH];
    int unsigned     held_n;
    int              low_val;
    int              high_val;
    logic [GAP_W-1:0] min_gap;
    int unsigned     cap_limit;
    out_t            expected_spans[$];
    int unsigned     errors;

    function new();
      held_n    = 0;
      low_val   = 0;
      high_val  = 0;
      min_gap   = '1;
      cap_limit = 64;
      errors    = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] limit);
      cap_limit = limit;
    endfunction

    function out_t predict_spans(in_t item);
      out_t        res;
      int unsigned cap;
      int          v;
      longint      diff;
      longint      span;
      v   = item.value;
      cap = (cap_limit < STORE_DEPTH) ? cap_limit : STORE_DEPTH;
      res = '0;
      if (item.op == OP_CLEAR) begin
        held_n   = 0;
        low_val  = 0;
        high_val = 0;
        min_gap  = '1;
      end else if (held_n >= cap) begin
        res.refused = 1'b1;
      end else begin
        // Smallest pairwise difference equals the smallest sorted-neighbor gap.
        for (int k = 0; k < held_n; k++) begin
          diff = longint'(v) - longint'(held_vals[k]);
          if (diff < 0) diff = -diff;
          if (diff[GAP_W-1:0] < min_gap) min_gap = diff[GAP_W-1:0];
        end
        if (held_n == 0) begin
          low_val  = v;
          high_val = v;
        end else begin
          if (v < low_val) low_val = v;
          if (v > high_val) high_val = v;
        end
        held_vals[held_n % STORE_DEPTH] = v;
        held_n++;
      end
      res.held_count = held_n[CAP_W-1:0];
      if (held_n >= 2) begin
        span = longint'(high_val) - longint'(low_val);
        res.shortest_span = min_gap[VAL_W-1:0];
        res.longest_span  = span[VAL_W-1:0];
      end
      return res;
    endfunction

    function void note_item(in_t item);
      expected_spans.insert(expected_spans.size(), predict_spans(item));
    endfunction

    function void report(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_spans.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_spans.pop_front();
      if (got.refused !== want.refused)
        report("refused", VAL_W'(want.refused), VAL_W'(got.refused));
      if (got.held_count !== want.held_count)
        report("held_count", VAL_W'(want.held_count), VAL_W'(got.held_count));
      if (got.shortest_span !== want.shortest_span)
        report("shortest_span", want.shortest_span, got.shortest_span);
      if (got.longest_span !== want.longest_span)
        report("longest_span", want.longest_span, got.longest_span);
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;

  span_scoreboard sb = new();
  int unsigned    results_seen = 0;
  int unsigned    stall_cycles = 0;

  set_min_max_gap_tracker #(.MAX_ENTRIES(STORE_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor. Both channels are sampled at the rising edge; an input transfer is noted
  // before a result in the same cycle is checked, though the block's latency keeps the
  // two apart anyway. The stall counter feeds the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("set_min_max_gap_tracker verification failed");
    $finish;
  end

  // Receiver. out_ready follows a mode redrawn after each random window: always
  // ready, coin flip, mostly stalled, mostly ready. Once, after HOLD_AT results, it
  // holds off for HOLD_CYCLES so the queue fills and the block stalls its input.
  initial begin
    int  mode;
    int  window;
    bit  hold_done;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      mode   = $urandom_range(0, 3);
      window = $urandom_range(20, 80);
      for (int c = 0; c < window; c++) begin
        @(negedge clk);
        if (!hold_done && results_seen >= HOLD_AT) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // Offers one item and returns at the rising edge where it is transferred. A following
  // call keeps valid high, so back-to-back items leave no gap with valid low.
  task automatic send_item(logic op, logic signed [VAL_W-1:0] val);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_data.op    <= op;
    in_data.value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender gap with valid low; its length grows with n.
  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has come back, so that the
  // block is idle and the capacity register may be written.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] limit);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= limit;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_capacity(limit);
  endtask

  // Value for an add. Each phase draws from one pattern: full 32-bit random, a tight
  // cluster that makes duplicates and small gaps, the extremes of the range, or a
  // small window around zero.
  function automatic logic signed [VAL_W-1:0] pick_value(int mode, int base);
    case (mode)
      0: return $urandom;
      1: return base + $urandom_range(0, 15);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  initial begin
    int               sent;
    int               mode;
    int               base;
    int               len;
    int               burst_left;
    bit               no_gaps;
    logic             op;
    logic [CAP_W-1:0] limit;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, at the reset capacity of 64. Extremes of the value range give the
    // widest span; a repeated value gives a gap of zero.
    send_item(OP_ADD, 32'sh8000_0000);
    send_item(OP_ADD, 32'sh7FFF_FFFF);
    send_item(OP_ADD, 0);
    send_item(OP_ADD, 0);
    send_item(OP_ADD, -1);
    send_item(OP_CLEAR, 32'shFFFF_FFFF);     // the value on a clear is ignored
    send_item(OP_ADD, 5);
    send_item(OP_CLEAR, 0);                  // clear with one value held
    send_item(OP_CLEAR, 32'sh5555_AAAA);     // clear of an empty set
    drain();

    // Capacity zero refuses even the first add.
    write_capacity(7'd0);
    send_item(OP_ADD, 123);
    drain();
    // Capacity two: the third add is refused and the spans stay as they were.
    write_capacity(7'd2);
    send_item(OP_ADD, 10);
    send_item(OP_ADD, -10);
    send_item(OP_ADD, 7);
    drain();
    // Lowering the capacity below the count refuses further adds without losing values.
    write_capacity(7'd1);
    send_item(OP_ADD, 11);
    send_item(OP_CLEAR, 0);
    send_item(OP_ADD, 11);
    send_item(OP_ADD, 12);
    drain();
    // A limit above the store size acts as the store size.
    write_capacity(7'd127);
    send_item(OP_ADD, 32'sh7FFF_FFFF);
    send_item(OP_ADD, 32'sh7FFF_FFFE);
    send_item(OP_CLEAR, 0);
    drain();
    write_capacity(7'd65);

    // Random part in phases. Each phase may change the capacity while idle, may start
    // from an empty set or keep what is held, and then streams mostly adds with rare
    // clears, so the set regularly fills up and refusals follow.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: limit = 7'd0;
          1: limit = 7'd1;
          2: limit = 7'd2;
          3, 4: limit = 7'd64;
          5: limit = 7'd65;
          6: limit = 7'd127;
          7: limit = CAP_W'($urandom_range(3, 20));
          default: limit = CAP_W'($urandom_range(0, 127));
        endcase
        write_capacity(limit);
      end
      mode       = $urandom_range(0, 3);
      base       = $urandom;
      len        = $urandom_range(20, 120);
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 1) == 0) begin
        send_item(OP_CLEAR, $urandom);
        sent++;
      end
      for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        if (!no_gaps && burst_left == 0) begin
          pause_sender($urandom_range(1, 8));
          burst_left = $urandom_range(1, 30);
        end
        op = ($urandom_range(0, 29) == 0) ? OP_CLEAR : OP_ADD;
        send_item(op, pick_value(mode, base));
        if (burst_left > 0) burst_left--;
        sent++;
      end
    end

    // Let everything outstanding come back, then give a late or extra result time to show.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("set_min_max_gap_tracker verification clean");
    end else begin
      $display("set_min_max_gap_tracker verification failed");
    end
    $finish;
  end

endmodule
